[rtl/fnc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FAT next-cluster lookup package
// Shared widths, sizes, request, mode and status codes, end limits, register indexes.
// -----------------------------------------------------------------------------
package fnc_pkg;

  localparam int FatBytes    = 65536;
  localparam int SectorBytes = 512;
  localparam int AddrW       = $clog2(FatBytes);
  localparam int SecShift    = $clog2(SectorBytes);

  localparam int ByteAddrW   = 16;
  localparam int ByteW       = 8;
  localparam int ClusterW    = 28;
  localparam int StatusW     = 2;
  localparam int ModeW       = 2;
  localparam int SectorsW    = 16;
  localparam int PosW        = ClusterW + 2;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 28;

  localparam logic ReqLoad   = 1'b0;
  localparam logic ReqLookup = 1'b1;

  localparam logic [ModeW-1:0] ModeFat12 = 2'd0;
  localparam logic [ModeW-1:0] ModeFat16 = 2'd1;
  localparam logic [ModeW-1:0] ModeFat32 = 2'd2;

  localparam logic [StatusW-1:0] StatusNext    = 2'd0;
  localparam logic [StatusW-1:0] StatusEnd     = 2'd1;
  localparam logic [StatusW-1:0] StatusInvalid = 2'd2;
  localparam logic [StatusW-1:0] StatusBeyond  = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgFatMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxCluster = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFatSectors = 2'd2;

  localparam logic [11:0]         Fat12EndLimit = 12'hFF0;
  localparam logic [15:0]         Fat16EndLimit = 16'hFFF0;
  localparam logic [ClusterW-1:0] Fat32EndLimit = 28'hFFFFFF0;

endpackage
`default_nettype wire

[rtl/fnc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FAT next-cluster lookup channels
// Valid/ready request and response channels with their payload fields.
// -----------------------------------------------------------------------------
interface fnc_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [fnc_pkg::ByteAddrW-1:0]  byte_address;
  logic [fnc_pkg::ByteW-1:0]      byte_value;
  logic [fnc_pkg::ClusterW-1:0]   cluster;

  modport source (output valid, req_type, byte_address, byte_value, cluster,
                  input ready);
  modport sink   (input valid, req_type, byte_address, byte_value, cluster,
                  output ready);
endinterface

interface fnc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [fnc_pkg::ClusterW-1:0]   next_cluster;
  logic [fnc_pkg::StatusW-1:0]    status;

  modport source (output valid, next_cluster, status, input ready);
  modport sink   (input valid, next_cluster, status, output ready);
endinterface
`default_nettype wire

[rtl/fnc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module fnc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/fat_next_cluster_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// FAT next-cluster lookup
// Byte-wide FAT store with a sequencer that assembles and decodes one entry.
// -----------------------------------------------------------------------------
// Usage:
//   req_i carries load and lookup transactions. A load writes one byte into the
//   FAT store; it yields no response. A lookup computes the entry offset,
//   checks range, then reads the entry one byte per cycle through the single
//   RAM read port; the response is registered in the done step that follows
//   the capture of the last byte, or the range check when the cluster or entry
//   is rejected. req_i is held off while a lookup runs and accepts the next
//   transaction from the same clock edge that registers the response.
//   rsp_o carries one response per lookup from an output register; a
//   new transaction is accepted while a response waits. If the receiver
//   stalls, a finished lookup waits in its last step until the register frees.
//   cfg_we_i writes fat_mode, max_cluster and fat_sectors; write only while
//   idle. Reset clears the config registers and the control state; the
//   FAT store is not cleared and must be loaded before it is looked up.
// -----------------------------------------------------------------------------
module fat_next_cluster_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  fnc_req_if.sink                            req_i,
  fnc_rsp_if.source                          rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [fnc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [fnc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StRead = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  localparam int AddrW    = fnc_pkg::AddrW;
  localparam int PosW     = fnc_pkg::PosW;
  localparam int ClusterW = fnc_pkg::ClusterW;

  logic [1:0]                    state_q, state_d;
  logic [fnc_pkg::ModeW-1:0]     mode_q;
  logic [ClusterW-1:0]           max_cluster_q;
  logic [fnc_pkg::SectorsW-1:0]  fat_sectors_q;

  logic [ClusterW-1:0]           clu_q, clu_d;
  logic [AddrW-1:0]              pos_q, pos_d;
  logic [2:0]                    nbytes_q, nbytes_d;
  logic [2:0]                    rd_cnt_q, rd_cnt_d;
  logic                          cap_vld_q, cap_vld_d;
  logic [1:0]                    cap_idx_q, cap_idx_d;
  logic [31:0]                   val_q, val_d;
  logic [fnc_pkg::StatusW-1:0]   stat_q, stat_d;

  logic                          rsp_vld_q, rsp_vld_d;
  logic [ClusterW-1:0]           rsp_next_q, rsp_next_d;
  logic [fnc_pkg::StatusW-1:0]   rsp_stat_q, rsp_stat_d;

  logic                          req_fire;
  logic                          ram_we;
  logic                          ram_re;
  logic [AddrW-1:0]              ram_raddr;
  logic [fnc_pkg::ByteW-1:0]     ram_rdata;

  logic [PosW-1:0]               pos_c;
  logic [2:0]                    nbytes_c;
  logic                          invalid_c;
  logic                          beyond_c;
  logic                          done_fire;
  logic [11:0]                   e12;
  logic [ClusterW-1:0]           res_next;
  logic [fnc_pkg::StatusW-1:0]   res_stat;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  assign ram_we    = req_fire && (req_i.req_type == fnc_pkg::ReqLoad) &&
                     (int'(req_i.byte_address) < fnc_pkg::FatBytes);
  assign ram_re    = (state_q == StRead) && (rd_cnt_q < nbytes_q);
  assign ram_raddr = pos_q + AddrW'(rd_cnt_q);

  fnc_ram #(
    .Width (fnc_pkg::ByteW),
    .Depth (fnc_pkg::FatBytes)
  ) u_fat_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.byte_address[AddrW-1:0]),
    .wdata_i (req_i.byte_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (mode_q)
      fnc_pkg::ModeFat12: begin
        pos_c    = {2'b00, clu_q} + {3'b000, clu_q[ClusterW-1:1]};
        nbytes_c = 3'd2;
      end
      fnc_pkg::ModeFat16: begin
        pos_c    = {1'b0, clu_q, 1'b0};
        nbytes_c = 3'd2;
      end
      default: begin
        pos_c    = {clu_q, 2'b00};
        nbytes_c = 3'd4;
      end
    endcase
    invalid_c = (clu_q == '0) || (clu_q > max_cluster_q);
    beyond_c  = (pos_c[PosW-1:fnc_pkg::SecShift] >=
                 (PosW - fnc_pkg::SecShift)'(fat_sectors_q)) ||
                (pos_c > PosW'(fnc_pkg::FatBytes) - PosW'(nbytes_c));
  end

  always_comb begin
    e12      = clu_q[0] ? val_q[15:4] : val_q[11:0];
    res_next = '0;
    res_stat = stat_q;
    if (stat_q == fnc_pkg::StatusNext) begin
      case (mode_q)
        fnc_pkg::ModeFat12: begin
          if (e12 > fnc_pkg::Fat12EndLimit) begin
            res_stat = fnc_pkg::StatusEnd;
          end else begin
            res_next = {16'b0, e12};
          end
        end
        fnc_pkg::ModeFat16: begin
          if (val_q[15:0] > fnc_pkg::Fat16EndLimit) begin
            res_stat = fnc_pkg::StatusEnd;
          end else begin
            res_next = {12'b0, val_q[15:0]};
          end
        end
        default: begin
          if (val_q[ClusterW-1:0] > fnc_pkg::Fat32EndLimit) begin
            res_stat = fnc_pkg::StatusEnd;
          end else begin
            res_next = val_q[ClusterW-1:0];
          end
        end
      endcase
    end
  end

  assign done_fire = (state_q == StDone) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    clu_d      = clu_q;
    pos_d      = pos_q;
    nbytes_d   = nbytes_q;
    rd_cnt_d   = rd_cnt_q;
    cap_vld_d  = ram_re;
    cap_idx_d  = rd_cnt_q[1:0];
    val_d      = val_q;
    stat_d     = stat_q;
    rsp_vld_d  = rsp_vld_q && !rsp_o.ready;
    rsp_next_d = rsp_next_q;
    rsp_stat_d = rsp_stat_q;

    case (state_q)
      StIdle: begin
        if (req_fire && (req_i.req_type == fnc_pkg::ReqLookup)) begin
          clu_d   = req_i.cluster;
          state_d = StCalc;
        end
      end
      StCalc: begin
        pos_d    = pos_c[AddrW-1:0];
        nbytes_d = nbytes_c;
        rd_cnt_d = '0;
        if (invalid_c) begin
          stat_d  = fnc_pkg::StatusInvalid;
          state_d = StDone;
        end else if (beyond_c) begin
          stat_d  = fnc_pkg::StatusBeyond;
          state_d = StDone;
        end else begin
          stat_d  = fnc_pkg::StatusNext;
          state_d = StRead;
        end
      end
      StRead: begin
        if (ram_re) begin
          rd_cnt_d = rd_cnt_q + 3'd1;
        end
        if (cap_vld_q) begin
          val_d[{cap_idx_q, 3'b000} +: 8] = ram_rdata;
          if ({1'b0, cap_idx_q} == nbytes_q - 3'd1) begin
            state_d = StDone;
          end
        end
      end
      StDone: begin
        if (done_fire) begin
          rsp_vld_d  = 1'b1;
          rsp_next_d = res_next;
          rsp_stat_d = res_stat;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      rd_cnt_q      <= '0;
      cap_vld_q     <= 1'b0;
      rsp_vld_q     <= 1'b0;
      mode_q        <= fnc_pkg::ModeFat12;
      max_cluster_q <= '0;
      fat_sectors_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      cap_vld_q <= cap_vld_d;
      rsp_vld_q <= rsp_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fnc_pkg::CfgFatMode:    mode_q        <= cfg_data_i[fnc_pkg::ModeW-1:0];
          fnc_pkg::CfgMaxCluster: max_cluster_q <= cfg_data_i[ClusterW-1:0];
          fnc_pkg::CfgFatSectors: fat_sectors_q <= cfg_data_i[fnc_pkg::SectorsW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clu_q      <= clu_d;
    pos_q      <= pos_d;
    nbytes_q   <= nbytes_d;
    cap_idx_q  <= cap_idx_d;
    val_q      <= val_d;
    stat_q     <= stat_d;
    rsp_next_q <= rsp_next_d;
    rsp_stat_q <= rsp_stat_d;
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.next_cluster = rsp_next_q;
  assign rsp_o.status       = rsp_stat_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("FAT store written and read in the same cycle");

  a_read_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> (stat_q == fnc_pkg::StatusNext))
    else $error("entry read after a rejected lookup");

  a_capture_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_vld_q |-> (state_q == StRead))
    else $error("read data returned outside the read phase");

  a_lookup_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && (req_i.req_type == fnc_pkg::ReqLookup)) |=> (state_q == StCalc))
    else $error("accepted lookup did not start");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.status == fnc_pkg::StatusNext) ||
                     (rsp_o.next_cluster == '0)))
    else $error("nonzero next cluster with a failing status");

endmodule
`default_nettype wire
